### sv/xenc_pkg.sv
// xenc_pkg: shared types, operation and operand kind codes, helper functions
// for the x86-64 instruction encoder
// depends on nothing
package xenc_pkg;

	localparam int MaxAlign = 64;
	localparam int BufDepth = 16;

	typedef enum logic [4:0] {
		OP_ALIGN = 5'd0,  OP_ADD   = 5'd1,  OP_AND  = 5'd2,  OP_CALL = 5'd3,
		OP_CMP   = 5'd4,  OP_JL    = 5'd5,  OP_JMP  = 5'd6,  OP_JNS  = 5'd7,
		OP_JNZ   = 5'd8,  OP_JZ    = 5'd9,  OP_LABEL = 5'd10, OP_LEA = 5'd11,
		OP_MOV   = 5'd12, OP_MOVZX = 5'd13, OP_OR   = 5'd14, OP_POP  = 5'd15,
		OP_PUSH  = 5'd16, OP_RET   = 5'd17, OP_HLT  = 5'd18
	} op_t;

	localparam logic [3:0] K_REG8   = 4'd0;
	localparam logic [3:0] K_REG32  = 4'd1;
	localparam logic [3:0] K_REG64  = 4'd2;
	localparam logic [3:0] K_IMM8   = 4'd3;
	localparam logic [3:0] K_IMM32  = 4'd4;
	localparam logic [3:0] K_MEM8   = 4'd5;
	localparam logic [3:0] K_MEMEXT = 4'd6;
	localparam logic [3:0] K_MEMLOC = 4'd7;
	localparam logic [3:0] K_MEMLBL = 4'd8;
	localparam logic [3:0] K_MEMREL = 4'd9;
	localparam logic [3:0] K_LABEL  = 4'd12;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  base;
		logic [3:0]  index;
		logic [31:0] value;
	} opnd_t;

	typedef struct packed {
		logic [4:0]  operation;
		opnd_t       dst;
		opnd_t       src;
		logic [63:0] target_address;
		logic [6:0]  align_bytes;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DEC  = 4'b0010,
		ST_REL  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	function automatic logic is_rip(logic [3:0] k);
		return (k >= K_MEMEXT) && (k <= K_MEMREL);
	endfunction

	function automatic logic is_rel(logic [3:0] k);
		return (k >= K_MEMEXT) && (k <= K_LABEL);
	endfunction

	function automatic logic fits8(logic [31:0] v);
		return (v[31:7] == '0) || (v[31:7] == '1);
	endfunction

	function automatic logic [7:0] rex_byte(opnd_t m, logic [3:0] reg_n);
		logic w;
		w = (m.kind == K_REG64) || is_rip(m.kind);
		return {4'h4, w, reg_n[3], m.index[3], m.base[3]};
	endfunction

	function automatic logic [7:0] modrm_byte(opnd_t m, logic [2:0] reg_n);
		if (m.kind == K_MEM8) begin
			return {2'b10, reg_n, 3'b100};
		end else if (is_rip(m.kind)) begin
			return {2'b00, reg_n, 3'b101};
		end
		return {2'b11, reg_n, m.base[2:0]};
	endfunction

endpackage

### sv/xenc_if.sv
// xenc_in_if / xenc_out_if: valid-ready channels of the encoder
// depends on nothing
interface xenc_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  operation;
	logic [3:0]  dst_kind;
	logic [3:0]  dst_base_reg;
	logic [3:0]  dst_index_reg;
	logic signed [31:0] dst_value;
	logic [3:0]  src_kind;
	logic [3:0]  src_base_reg;
	logic [3:0]  src_index_reg;
	logic signed [31:0] src_value;
	logic [63:0] target_address;
	logic [6:0]  align_bytes;
	modport source (output valid, operation, dst_kind, dst_base_reg, dst_index_reg,
		dst_value, src_kind, src_base_reg, src_index_reg, src_value, target_address,
		align_bytes, input ready);
	modport sink (input valid, operation, dst_kind, dst_base_reg, dst_index_reg,
		dst_value, src_kind, src_base_reg, src_index_reg, src_value, target_address,
		align_bytes, output ready);
endinterface

interface xenc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       last_byte;
	logic       unsupported;
	modport source (output valid, code_byte, last_byte, unsupported, input ready);
	modport sink (input valid, code_byte, last_byte, unsupported, output ready);
endinterface

### sv/x86_64_instruction_encoder_top.sv
// x86_64_instruction_encoder_top: turns one abstract instruction into x86-64 code bytes
// depends on xenc_pkg and the channel interfaces in xenc_if.sv
//
// One instruction beat is taken while the block is idle. The next cycle decodes it into
// a byte buffer (prefix, opcode, ModR/M, SIB, displacement, immediate); when the
// instruction has a relative field, the REL state runs the shared 32-bit subtractor to
// form target minus the address of the following instruction and patches the buffer.
// A short jump whose offset does not fit a byte goes back through decode once in long
// form. Then one code byte beat leaves per cycle while out_ch.ready is high, and
// last_byte marks the final one. A label emits nothing; align emits its NOP run one
// byte a cycle while out_ch.ready is high. An unencodable combination gives one beat with
// code_byte 0 and unsupported set, and the code address stays put. Writing cfg_data
// with cfg_we sets the code address; write it only while idle.
module x86_64_instruction_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_data,
	xenc_in_if.sink     in_ch,
	xenc_out_if.source  out_ch
);
	import xenc_pkg::*;

	state_t      state_q;
	item_t       item_q;
	logic [63:0] addr_q;
	logic [7:0]  buf_q [BufDepth];
	logic [4:0]  len_q;
	logic [3:0]  relpos_q;
	logic [2:0]  relsz_q;
	logic        unsup_q;
	logic        br_q;
	logic        long_q;
	logic        align_q;
	logic [5:0]  mask_q;
	logic [5:0]  idx_q;
	logic [31:0] base_q;

	// decode controls
	logic        fail, is_br, rex_en, mod_en, imm_rel;
	logic [7:0]  rex_v, op0, op1;
	logic [1:0]  opn;
	opnd_t       mod_m;
	logic [2:0]  mod_reg;
	logic [2:0]  imm_n;
	logic [31:0] imm_v;

	// assembled buffer
	logic [7:0]  b [BufDepth];
	logic [4:0]  n;
	logic [3:0]  relpos;
	logic [2:0]  relsz;

	opnd_t d, s;
	assign d = item_q.dst;
	assign s = item_q.src;

	// alu helper: num is the /digit of the group opcode
	function automatic void alu_dec(input logic [2:0] num, input opnd_t dd, input opnd_t ss,
		output logic f, output logic re, output logic [7:0] rv, output logic [7:0] o0,
		output logic [2:0] mr, output logic [2:0] inn, output logic [31:0] iv);
		f = 1'b0; re = 1'b0; rv = 8'h40; o0 = 8'h00; mr = num; inn = 3'd0; iv = ss.value;
		case (ss.kind)
			K_IMM8: begin
				rv = rex_byte(dd, {1'b0, num}); o0 = 8'h80; inn = 3'd1;
			end
			K_IMM32: begin
				rv = rex_byte(dd, {1'b0, num});
				if (fits8(ss.value)) begin
					o0 = 8'h83; inn = 3'd1;
				end else begin
					o0 = 8'h81; inn = 3'd4;
				end
			end
			K_REG8: begin
				rv = rex_byte(dd, ss.base); o0 = {2'b00, num, 3'b000}; mr = ss.base[2:0];
			end
			K_REG32, K_REG64: begin
				rv = rex_byte(dd, ss.base); o0 = {2'b00, num, 3'b001}; mr = ss.base[2:0];
			end
			default: f = 1'b1;
		endcase
		re = (rv != 8'h40);
	endfunction

	always_comb begin
		fail = 1'b0; is_br = 1'b0; rex_v = 8'h40; opn = 2'd1; op0 = 8'h00; op1 = 8'h00;
		mod_en = 1'b0; mod_m = d; mod_reg = 3'd0; imm_n = 3'd0; imm_v = 32'd0;
		imm_rel = 1'b0;
		case (item_q.operation)
			OP_ADD: begin
				alu_dec(3'd0, d, s, fail, rex_en, rex_v, op0, mod_reg, imm_n, imm_v);
				mod_en = 1'b1;
			end
			OP_AND: begin
				alu_dec(3'd4, d, s, fail, rex_en, rex_v, op0, mod_reg, imm_n, imm_v);
				mod_en = 1'b1;
			end
			OP_CMP: begin
				alu_dec(3'd7, d, s, fail, rex_en, rex_v, op0, mod_reg, imm_n, imm_v);
				mod_en = 1'b1;
			end
			OP_OR: begin
				alu_dec(3'd1, d, s, fail, rex_en, rex_v, op0, mod_reg, imm_n, imm_v);
				mod_en = 1'b1;
			end
			OP_CALL: begin
				if (!is_rel(d.kind)) fail = 1'b1;
				op0 = 8'he8; imm_n = 3'd4; imm_rel = 1'b1;
			end
			OP_JL, OP_JMP, OP_JNS, OP_JNZ, OP_JZ: begin
				if (item_q.operation == OP_JMP && d.kind == K_MEMREL) begin
					op0 = 8'hff; mod_en = 1'b1; mod_reg = 3'd4;
				end else if (!is_rel(d.kind)) begin
					fail = 1'b1;
				end else begin
					is_br = 1'b1; imm_rel = 1'b1;
					if (!long_q) begin
						imm_n = 3'd1;
						case (item_q.operation)
							OP_JL:   op0 = 8'h7c;
							OP_JMP:  op0 = 8'heb;
							OP_JNS:  op0 = 8'h79;
							OP_JNZ:  op0 = 8'h75;
							default: op0 = 8'h74;
						endcase
					end else begin
						imm_n = 3'd4; opn = 2'd2; op0 = 8'h0f;
						case (item_q.operation)
							OP_JL:  op1 = 8'h8c;
							OP_JMP: begin
								opn = 2'd1; op0 = 8'he9;
							end
							OP_JNS:  op1 = 8'h89;
							OP_JNZ:  op1 = 8'h85;
							default: op1 = 8'h84;
						endcase
					end
				end
			end
			OP_LABEL: opn = 2'd0;
			OP_ALIGN: opn = 2'd0;
			OP_LEA: begin
				rex_v = rex_byte(s, d.base); op0 = 8'h8d;
				mod_en = 1'b1; mod_m = s; mod_reg = d.base[2:0];
			end
			OP_MOVZX: begin
				rex_v = rex_byte(s, d.base); opn = 2'd2; op0 = 8'h0f; op1 = 8'hb6;
				mod_en = 1'b1; mod_m = s; mod_reg = d.base[2:0];
			end
			OP_MOV: begin
				if (d.kind == K_MEM8) begin
					mod_en = 1'b1;
					if (s.kind == K_REG8) begin
						rex_v = rex_byte(d, s.base); op0 = 8'h88; mod_reg = s.base[2:0];
					end else if (s.kind == K_IMM8) begin
						rex_v = rex_byte(d, 4'd0); op0 = 8'hc6;
						imm_n = 3'd1; imm_v = s.value;
					end else fail = 1'b1;
				end else if (d.kind == K_REG8) begin
					rex_v = rex_byte(s, d.base); op0 = 8'h8a;
					mod_en = 1'b1; mod_m = s; mod_reg = d.base[2:0];
				end else if (d.kind == K_REG32 || d.kind == K_REG64) begin
					if (s.kind == K_IMM32) begin
						rex_v = rex_byte(d, 4'd0); imm_n = 3'd4; imm_v = s.value;
						if (d.kind == K_REG32) begin
							op0 = {5'b10111, d.base[2:0]};
						end else begin
							op0 = 8'hc7; mod_en = 1'b1;
						end
					end else if (s.kind == K_MEMEXT || s.kind == K_MEMLOC) begin
						rex_v = rex_byte(s, d.base); op0 = 8'h8b;
						mod_en = 1'b1; mod_m = s; mod_reg = d.base[2:0];
					end else if (s.kind == K_REG32 || s.kind == K_REG64) begin
						rex_v = rex_byte(d, s.base); op0 = 8'h89;
						mod_en = 1'b1; mod_reg = s.base[2:0];
					end else fail = 1'b1;
				end else fail = 1'b1;
			end
			OP_POP: begin
				if (d.base[3]) begin
					opn = 2'd2; op0 = 8'h41; op1 = {5'b01011, d.base[2:0]};
				end else op0 = {5'b01011, d.base[2:0]};
			end
			OP_PUSH: begin
				if (s.kind == K_MEMREL) begin
					op0 = 8'hff; mod_en = 1'b1; mod_m = s; mod_reg = 3'd6;
				end else if (s.kind == K_IMM32) begin
					op0 = 8'h68; imm_n = 3'd4; imm_v = s.value;
				end else if (s.base[3]) begin
					opn = 2'd2; op0 = 8'h41; op1 = {5'b01010, s.base[2:0]};
				end else op0 = {5'b01010, s.base[2:0]};
			end
			OP_RET: op0 = 8'hc3;
			OP_HLT: op0 = 8'hf4;
			default: fail = 1'b1;
		endcase
		rex_en = (rex_v != 8'h40);
	end

	// lay the fields out in byte order
	always_comb begin
		for (int i = 0; i < BufDepth; i++) b[i] = 8'h00;
		n = 5'd0; relpos = 4'd0; relsz = 3'd0;
		if (rex_en) begin
			b[n[3:0]] = rex_v; n = n + 5'd1;
		end
		if (opn != 2'd0) begin
			b[n[3:0]] = op0; n = n + 5'd1;
		end
		if (opn == 2'd2) begin
			b[n[3:0]] = op1; n = n + 5'd1;
		end
		if (mod_en) begin
			b[n[3:0]] = modrm_byte(mod_m, mod_reg); n = n + 5'd1;
			if (mod_m.kind == K_MEM8) begin
				b[n[3:0]] = {2'b00, mod_m.index[2:0], mod_m.base[2:0]}; n = n + 5'd1;
				for (int k = 0; k < 4; k++) begin
					b[n[3:0]] = mod_m.value[8*k +: 8]; n = n + 5'd1;
				end
			end else if (is_rip(mod_m.kind)) begin
				relpos = n[3:0]; relsz = 3'd4; n = n + 5'd4;
			end
		end
		if (imm_rel) begin
			relpos = n[3:0]; relsz = imm_n;
		end
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < imm_n) begin
				b[n[3:0]] = imm_v[8*k +: 8]; n = n + 5'd1;
			end
		end
		if (fail) begin
			for (int i = 0; i < BufDepth; i++) b[i] = 8'h00;
			n = 5'd1; relsz = 3'd0;
		end
	end

	// shared subtractor: rel offset from the address after the instruction
	logic [31:0] disp;
	assign disp = base_q - {27'd0, len_q};

	// align: clamp to the largest alignment and form the address mask
	logic [6:0] al_a;
	logic [5:0] al_m;
	always_comb begin
		al_a = (item_q.align_bytes > 7'(MaxAlign)) ? 7'(MaxAlign) : item_q.align_bytes;
		al_m = 6'(al_a - 7'd1);
	end

	logic       out_last;
	logic [5:0] nxt_low;
	assign nxt_low = addr_q[5:0] + 6'd1;
	assign out_last = align_q ? ((nxt_low & mask_q) == 6'd0)
		: (idx_q == 6'(len_q - 5'd1));

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = (state_q == ST_EMIT);
	assign out_ch.code_byte   = align_q ? 8'h90 : buf_q[idx_q[3:0]];
	assign out_ch.last_byte   = out_last;
	assign out_ch.unsupported = unsup_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			long_q  <= 1'b0;
			align_q <= 1'b0;
			unsup_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cfg_we) addr_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						item_q <= '{in_ch.operation,
							'{in_ch.dst_kind, in_ch.dst_base_reg, in_ch.dst_index_reg,
								in_ch.dst_value},
							'{in_ch.src_kind, in_ch.src_base_reg, in_ch.src_index_reg,
								in_ch.src_value},
							in_ch.target_address, in_ch.align_bytes};
						long_q  <= 1'b0;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					for (int i = 0; i < BufDepth; i++) buf_q[i] <= b[i];
					len_q    <= n;
					relpos_q <= relpos;
					relsz_q  <= relsz;
					unsup_q  <= fail;
					br_q     <= is_br;
					base_q   <= item_q.target_address[31:0] - addr_q[31:0];
					mask_q   <= al_m;
					idx_q    <= '0;
					align_q  <= (item_q.operation == OP_ALIGN);
					if (item_q.operation == OP_ALIGN) begin
						if (al_a == 7'd0 || (addr_q[5:0] & al_m) == 6'd0) state_q <= ST_IDLE;
						else state_q <= ST_EMIT;
					end else if (n == 5'd0) begin
						state_q <= ST_IDLE;
					end else if (relsz != 3'd0) begin
						state_q <= ST_REL;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_REL: begin
					if (br_q && !long_q && !fits8(disp)) begin
						// short jump out of reach: redo in long form
						long_q  <= 1'b1;
						state_q <= ST_DEC;
					end else begin
						for (int k = 0; k < 4; k++) begin
							if (3'(k) < relsz_q) buf_q[4'(relpos_q + 4'(k))] <= disp[8*k +: 8];
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						if (!unsup_q) addr_q <= addr_q + 64'd1;
						idx_q <= idx_q + 6'd1;
						if (out_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
